// ===== hw/rtl/cht_pkg.sv =====
package cht_pkg;

    localparam int ENTRIES = 256;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;

    localparam logic [1:0] ACT_GET    = 2'd0;
    localparam logic [1:0] ACT_SET    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

endpackage

// ===== hw/rtl/cht_ram.sv =====
module cht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/coalesced_hash_table_core.sv =====
// Channel  Ports                              Direction
// s_       s_valid s_ready s_action s_key      in   one get/set/remove item
//          s_value
// m_       m_valid m_ready m_status m_found   out  one result per item
//          m_value_out
//
// Each chain step walked is a table read, then a check; a set then probes
// upward from the chain tail to an empty slot and links the new entry behind
// an occupied tail. The single read port of the link/key store sets the walk
// pace. Zero-value and full-table sets return an error without a walk.
// Reset clears occupancy, not RAMs; link words count only in occupied slots.
// A result waits in the output register; the next item is taken meanwhile.
module coalesced_hash_table_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_action,
    input  logic [cht_pkg::KEY_W-1:0] s_key,
    input  logic [cht_pkg::VAL_W-1:0] s_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_status,
    output logic                 m_found,
    output logic [cht_pkg::VAL_W-1:0] m_value_out
);
    import cht_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_CHK   = 3'd2;
    localparam logic [2:0] ST_PROBE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;
    localparam logic [2:0] ST_LINK  = 3'd5;

    logic [2:0]       state_reg;
    logic [1:0]       act_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    idx_t             cur_reg;
    idx_t             idx_reg;
    cnt_t             steps_reg;
    cnt_t             count_reg;
    logic [ENTRIES-1:0] occ_reg;
    logic             res_status_reg;
    logic             res_found_reg;
    logic [VAL_W-1:0] res_value_reg;
    logic             m_valid_reg;
    logic             m_status_reg;
    logic             m_found_reg;
    logic [VAL_W-1:0] m_value_reg;

    logic [KEY_W-1:0] key_rd;
    logic [VAL_W-1:0] val_rd;
    logic [IDX_W:0]   nxt_rd;
    logic [IDX_W:0]   prv_rd;

    logic             key_we, val_we, nxt_we, prv_we;
    idx_t             key_wa, val_wa, nxt_wa, prv_wa;
    logic [IDX_W:0]   nxt_wd, prv_wd;

    logic             nv_cur;
    logic             pv_cur;
    logic             walk_more;
    logic             hit;
    logic             step_limit;
    logic             out_free;

    // link word: valid bit on top, slot index below
    assign nv_cur     = occ_reg[cur_reg] && nxt_rd[IDX_W];
    assign pv_cur     = occ_reg[cur_reg] && prv_rd[IDX_W];
    assign walk_more  = nv_cur && (act_reg == ACT_SET || key_rd != key_reg);
    assign hit        = occ_reg[cur_reg] && key_rd == key_reg;
    assign step_limit = steps_reg >= CNT_W'(ENTRIES);
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = state_reg == ST_IDLE;

    always_comb begin
        key_we = 1'b0;
        val_we = 1'b0;
        nxt_we = 1'b0;
        prv_we = 1'b0;
        key_wa = idx_reg;
        val_wa = idx_reg;
        nxt_wa = idx_reg;
        prv_wa = idx_reg;
        nxt_wd = '0;
        prv_wd = '0;
        case (state_reg)
            ST_CHK: begin
                if (act_reg == ACT_REMOVE && !(walk_more && !step_limit) && hit) begin
                    nxt_we = pv_cur;
                    nxt_wa = prv_rd[IDX_W-1:0];
                    nxt_wd = {nv_cur, nxt_rd[IDX_W-1:0]};
                    prv_we = nv_cur;
                    prv_wa = nxt_rd[IDX_W-1:0];
                    prv_wd = {pv_cur, prv_rd[IDX_W-1:0]};
                end
            end
            ST_PROBE: begin
                if (!occ_reg[idx_reg]) begin
                    key_we = 1'b1;
                    val_we = 1'b1;
                    nxt_we = 1'b1;
                    prv_we = 1'b1;
                    if (idx_reg != cur_reg) begin
                        prv_wd = {1'b1, cur_reg};
                    end
                end
            end
            ST_LINK: begin
                nxt_we = 1'b1;
                nxt_wa = cur_reg;
                nxt_wd = {1'b1, idx_reg};
            end
            default: begin
            end
        endcase
    end

    cht_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .aclk(aclk), .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_reg),
        .rd_addr(cur_reg), .rd_data(key_rd)
    );
    cht_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
        .aclk(aclk), .wr_en(val_we), .wr_addr(val_wa), .wr_data(val_reg),
        .rd_addr(cur_reg), .rd_data(val_rd)
    );
    cht_ram #(.WIDTH(IDX_W + 1), .DEPTH(ENTRIES)) u_nxt_ram (
        .aclk(aclk), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
        .rd_addr(cur_reg), .rd_data(nxt_rd)
    );
    cht_ram #(.WIDTH(IDX_W + 1), .DEPTH(ENTRIES)) u_prv_ram (
        .aclk(aclk), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
        .rd_addr(cur_reg), .rd_data(prv_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        act_reg        <= s_action;
                        key_reg        <= s_key;
                        val_reg        <= s_value;
                        cur_reg        <= s_key[IDX_W-1:0];
                        steps_reg      <= '0;
                        res_status_reg <= 1'b0;
                        res_found_reg  <= 1'b0;
                        res_value_reg  <= '0;
                        if (s_action == ACT_GET || s_action == ACT_REMOVE) begin
                            state_reg <= ST_RD;
                        end else if (s_action == ACT_SET && s_value != '0
                                     && count_reg < CNT_W'(ENTRIES)) begin
                            state_reg <= ST_RD;
                        end else begin
                            res_status_reg <= 1'b1;
                            state_reg      <= ST_DONE;
                        end
                    end
                end
                ST_RD: begin
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    if (walk_more && !step_limit) begin
                        cur_reg   <= nxt_rd[IDX_W-1:0];
                        steps_reg <= steps_reg + cnt_t'(1);
                        state_reg <= ST_RD;
                    end else if (act_reg == ACT_SET) begin
                        if (walk_more) begin
                            res_status_reg <= 1'b1;
                            state_reg      <= ST_DONE;
                        end else begin
                            idx_reg   <= cur_reg;
                            steps_reg <= '0;
                            state_reg <= ST_PROBE;
                        end
                    end else begin
                        res_found_reg <= hit;
                        if (act_reg == ACT_GET && hit) begin
                            res_value_reg <= val_rd;
                        end
                        if (act_reg == ACT_REMOVE && hit) begin
                            occ_reg[cur_reg] <= 1'b0;
                            if (count_reg != '0) begin
                                count_reg <= count_reg - cnt_t'(1);
                            end
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_PROBE: begin
                    if (occ_reg[idx_reg]) begin
                        if (step_limit) begin
                            res_status_reg <= 1'b1;
                            state_reg      <= ST_DONE;
                        end else begin
                            idx_reg   <= idx_reg + idx_t'(1);
                            steps_reg <= steps_reg + cnt_t'(1);
                        end
                    end else begin
                        occ_reg[idx_reg] <= 1'b1;
                        count_reg <= count_reg + cnt_t'(1);
                        if (idx_reg != cur_reg) begin
                            state_reg <= ST_LINK;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_LINK: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_found_reg  <= res_found_reg;
                        m_value_reg  <= res_value_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_found     = m_found_reg;
    assign m_value_out = m_value_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count out of range");

    a_count_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(occ_reg) == int'(count_reg))
        else $error("entry count disagrees with occupancy");

    a_no_err_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_status_reg && m_found_reg))
        else $error("error result marked found");

    a_link_after_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LINK |-> $past(state_reg) == ST_PROBE)
        else $error("link step without a probe");

endmodule
